// ===== rtl/bcba_pkg.sv =====
// Shared types, codes and field widths of the contiguous block allocator.
package bcba_pkg;

   localparam int ACTION_W     = 2;
   localparam int WORD_INDEX_W = 9;
   localparam int WORD_DATA_W  = 64;
   localparam int COUNT_W      = 16;
   localparam int STATUS_W     = 3;
   localparam int PHYS_W       = 31;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOMAP = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FEW   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NORUN = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_NUM  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENT    = 2'd2;

   localparam logic [COUNT_W-1:0] GROUP_SIZE_RESET = 16'd32768;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SET_FREE,
      CMD_ALLOC,
      CMD_REPORT
   } cmd_kind_type;

   // A classified request as it waits in the command queue.
   typedef struct packed {
      cmd_kind_type             kind;
      logic [STATUS_W-1:0]      status;
      logic [WORD_INDEX_W-1:0]  word_index;
      logic [WORD_DATA_W-1:0]   word_data;
      logic [COUNT_W-1:0]       value;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] group_size;
      logic [COUNT_W-1:0] group_number;
      logic               bitmap_present;
   } cfg_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK_RD,
      S_MARK_WR
   } back_state_type;

endpackage

// ===== rtl/bcba_intf.sv =====
// Request and response channel interfaces of the block allocator.
interface bcba_req_if import bcba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACTION_W-1:0]     action;
   logic [WORD_INDEX_W-1:0] word_index;
   logic [WORD_DATA_W-1:0]  word_data;
   logic [COUNT_W-1:0]      free_value;
   logic [COUNT_W-1:0]      alloc_count;

   modport source (output valid, action, word_index, word_data, free_value, alloc_count,
                   input ready);
   modport sink   (input valid, action, word_index, word_data, free_value, alloc_count,
                   output ready);
endinterface

interface bcba_rsp_if import bcba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PHYS_W-1:0]   physical_block;
   logic [COUNT_W-1:0]  free_left;

   modport source (output valid, status, physical_block, free_left, input ready);
   modport sink   (input valid, status, physical_block, free_left, output ready);
endinterface

// ===== rtl/bcba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bcba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bcba_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module bcba_front import bcba_pkg::*; #(
   parameter int MAP_WORDS = 512
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         bitmap_present,
   bcba_req_if.sink     req,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   cmd_type    q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd_new;
   logic       push;

   // Checks that need only the request and configuration are settled here.
   always_comb begin
      cmd_new.kind       = CMD_REPORT;
      cmd_new.status     = STATUS_OK;
      cmd_new.word_index = req.word_index;
      cmd_new.word_data  = req.word_data;
      cmd_new.value      = req.alloc_count;
      case (req.action)
         ACT_LOAD: begin
            if (32'(req.word_index) < MAP_WORDS) begin
               cmd_new.kind = CMD_LOAD;
            end
         end
         ACT_FREE: begin
            cmd_new.kind  = CMD_SET_FREE;
            cmd_new.value = req.free_value;
         end
         ACT_ALLOC: begin
            if (req.alloc_count == '0) begin
               cmd_new.status = STATUS_ZERO;
            end else if (!bitmap_present) begin
               cmd_new.status = STATUS_NOMAP;
            end else begin
               cmd_new.kind = CMD_ALLOC;
            end
         end
         default: begin
            cmd_new.kind = CMD_REPORT;
         end
      endcase
   end

   assign req.ready = enable && (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ cmd_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== rtl/bcba_back.sv =====
// Back end: bitmap memory, free count, first-fit scan, marking and result register.
module bcba_back import bcba_pkg::*; #(
   parameter int MAP_WORDS = 512,
   parameter int WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        clearing,
   bcba_rsp_if.source  rsp
);

   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int CNT_W      = $clog2(WORD_BITS + 1);
   localparam int NB         = $clog2(WORD_BITS) + 1;
   localparam int BW         = COUNT_W + 1;

   back_state_type state_ff, state_in;
   logic [AW-1:0]        clr_idx_ff, clr_idx_in;
   logic [COUNT_W-1:0]   free_ff, free_in;
   logic [COUNT_W-1:0]   need_ff, need_in;
   logic [COUNT_W-1:0]   limit_ff, limit_in;
   logic [31:0]          prod_ff;
   logic [AW-1:0]        iss_idx_ff, iss_idx_in;
   logic [BW-1:0]        iss_base_ff, iss_base_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        eval_idx_ff;
   logic [BW-1:0]        eval_base_ff;
   logic [BW-1:0]        run_ff, run_in;
   logic [COUNT_W-1:0]   first_ff, first_in;
   logic [AW-1:0]        first_word_ff, first_word_in;
   logic [OFF_W-1:0]     first_off_ff, first_off_in;
   logic [AW-1:0]        mark_word_ff, mark_word_in;
   logic [OFF_W-1:0]     mark_off_ff, mark_off_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   start_ff, start_in;
   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff;
   logic [PHYS_W-1:0]    out_phys_ff;
   logic [COUNT_W-1:0]   out_free_ff;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;

   logic                 res_valid;
   logic [STATUS_W-1:0]  res_status;
   logic [PHYS_W-1:0]    res_phys;
   logic [COUNT_W-1:0]   res_free;

   // Word evaluation signals.
   logic [BW-1:0]        avail;
   logic [WORD_BITS-1:0] free_w;
   logic [WORD_BITS:0]   pow_v, acc_v;
   logic [CNT_W-1:0]     tz, lz;
   logic                 s_found;
   logic [OFF_W-1:0]     s_idx;
   logic                 carry_hit, int_hit, issue;
   logic [BW-1:0]        space, taken;
   logic [WORD_BITS-1:0] mark_mask;

   bcba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign clearing = (state_ff == S_CLEAR);

   // Free-run detection over the word that the RAM presents.
   always_comb begin
      avail = {1'b0, limit_ff} - eval_base_ff;
      for (int p = 0; p < WORD_BITS; p++) begin
         free_w[p] = !rd_data[p] && (BW'(p) < avail);
      end
      tz = CNT_W'(WORD_BITS);
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (!free_w[p]) begin
            tz = CNT_W'(p);
         end
      end
      lz = CNT_W'(WORD_BITS);
      for (int p = 0; p < WORD_BITS; p++) begin
         if (!free_w[p]) begin
            lz = CNT_W'(WORD_BITS - 1 - p);
         end
      end
      // Build the mask of positions that start need_ff clear bits inside the word,
      // one power-of-two length at a time.
      pow_v = {1'b0, free_w};
      acc_v = '1;
      for (int i = 0; i < NB; i++) begin
         if (need_ff[i]) begin
            acc_v = pow_v & (acc_v >> (1 << i));
         end
         pow_v = pow_v & (pow_v >> (1 << i));
      end
      s_found = 1'b0;
      s_idx   = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (acc_v[p]) begin
            s_found = 1'b1;
            s_idx   = OFF_W'(p);
         end
      end
      carry_hit = (run_ff != '0) && (({1'b0, need_ff} - run_ff) <= BW'(tz));
      int_hit   = (need_ff <= COUNT_W'(WORD_BITS)) && s_found;
      issue     = iss_base_ff < {1'b0, limit_ff};
   end

   // Bits to set in the word being marked.
   always_comb begin
      space = BW'(WORD_BITS) - BW'(mark_off_ff);
      taken = ({1'b0, rem_ff} < space) ? {1'b0, rem_ff} : space;
      for (int p = 0; p < WORD_BITS; p++) begin
         mark_mask[p] = (BW'(p) >= BW'(mark_off_ff)) && (BW'(p) < BW'(mark_off_ff) + taken);
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      free_in       = free_ff;
      need_in       = need_ff;
      limit_in      = limit_ff;
      iss_idx_in    = iss_idx_ff;
      iss_base_in   = iss_base_ff;
      pend_in       = 1'b0;
      run_in        = run_ff;
      first_in      = first_ff;
      first_word_in = first_word_ff;
      first_off_in  = first_off_ff;
      mark_word_in  = mark_word_ff;
      mark_off_in   = mark_off_ff;
      rem_in        = rem_ff;
      start_in      = start_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_idx_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = iss_idx_ff;
      res_valid     = 1'b0;
      res_status    = STATUS_OK;
      res_phys      = '0;
      res_free      = free_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            limit_in = (32'(cfg.group_size) < TOTAL_BITS) ? cfg.group_size
                                                          : COUNT_W'(TOTAL_BITS);
            cmd_pop  = cmd_valid && (!out_valid_ff || rsp.ready);
            if (cmd_pop) begin
               case (cmd.kind)
                  CMD_LOAD: begin
                     wr_en     = 1'b1;
                     wr_addr   = AW'(cmd.word_index);
                     wr_data   = cmd.word_data[WORD_BITS-1:0];
                     res_valid = 1'b1;
                  end
                  CMD_SET_FREE: begin
                     free_in   = cmd.value;
                     res_free  = cmd.value;
                     res_valid = 1'b1;
                  end
                  CMD_ALLOC: begin
                     if (free_ff < cmd.value) begin
                        res_status = STATUS_FEW;
                        res_valid  = 1'b1;
                     end else begin
                        need_in     = cmd.value;
                        iss_idx_in  = '0;
                        iss_base_in = '0;
                        run_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     res_status = cmd.status;
                     res_valid  = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff && carry_hit) begin
               start_in     = first_ff;
               mark_word_in = first_word_ff;
               mark_off_in  = first_off_ff;
               rem_in       = need_ff;
               state_in     = S_MARK_RD;
            end else if (pend_ff && int_hit) begin
               start_in     = COUNT_W'(eval_base_ff + BW'(s_idx));
               mark_word_in = eval_idx_ff;
               mark_off_in  = s_idx;
               rem_in       = need_ff;
               state_in     = S_MARK_RD;
            end else if (!pend_ff && !issue) begin
               res_status = STATUS_NORUN;
               res_valid  = 1'b1;
               state_in   = S_IDLE;
            end else begin
               if (pend_ff) begin
                  if (tz == CNT_W'(WORD_BITS)) begin
                     if (run_ff == '0) begin
                        first_in      = COUNT_W'(eval_base_ff);
                        first_word_in = eval_idx_ff;
                        first_off_in  = '0;
                     end
                     run_in = run_ff + BW'(WORD_BITS);
                  end else begin
                     run_in        = BW'(lz);
                     first_in      = COUNT_W'(eval_base_ff + BW'(WORD_BITS) - BW'(lz));
                     first_word_in = eval_idx_ff;
                     first_off_in  = OFF_W'(CNT_W'(WORD_BITS) - lz);
                  end
               end
               if (issue) begin
                  rd_en       = 1'b1;
                  pend_in     = 1'b1;
                  iss_idx_in  = iss_idx_ff + AW'(1);
                  iss_base_in = iss_base_ff + BW'(WORD_BITS);
               end
            end
         end
         S_MARK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = mark_word_ff;
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            wr_en   = 1'b1;
            wr_addr = mark_word_ff;
            wr_data = rd_data | mark_mask;
            rem_in  = rem_ff - COUNT_W'(taken);
            if (rem_in == '0) begin
               free_in    = free_ff - need_ff;
               res_free   = free_ff - need_ff;
               res_phys   = PHYS_W'(prod_ff + 32'(start_ff));
               res_valid  = 1'b1;
               state_in   = S_IDLE;
            end else begin
               mark_word_in = mark_word_ff + AW'(1);
               mark_off_in  = '0;
               state_in     = S_MARK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = res_valid || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         free_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      need_ff       <= need_in;
      limit_ff      <= limit_in;
      prod_ff       <= cfg.group_number * cfg.group_size;
      iss_idx_ff    <= iss_idx_in;
      iss_base_ff   <= iss_base_in;
      eval_idx_ff   <= iss_idx_ff;
      eval_base_ff  <= iss_base_ff;
      run_ff        <= run_in;
      first_ff      <= first_in;
      first_word_ff <= first_word_in;
      first_off_ff  <= first_off_in;
      mark_word_ff  <= mark_word_in;
      mark_off_ff   <= mark_off_in;
      rem_ff        <= rem_in;
      start_ff      <= start_in;
      if (res_valid) begin
         out_status_ff <= res_status;
         out_phys_ff   <= res_phys;
         out_free_ff   <= res_free;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.status         = out_status_ff;
   assign rsp.physical_block = out_phys_ff;
   assign rsp.free_left      = out_free_ff;

endmodule

// ===== rtl/bitmap_contiguous_block_allocator_core.sv =====
// Top level of the first-fit contiguous bitmap block allocator.
//
// The block keeps one group's allocation bitmap and free-block count. Requests
// arrive on the req_chan channel: load a bitmap word, set the free count, or
// allocate a run of contiguous clear blocks. Every request yields exactly one
// transfer on rsp_chan with a status, the physical start block and the free
// count left. Group size, group number and the bitmap-present flag are written
// through the csr_ port; the user must do so only while no request is in flight,
// which the block itself does not enforce. A request waits in a two-entry
// command queue until the back end takes it. Loads, free-count writes and checks
// that fail early are answered through the result register as soon as the back
// end takes them. An allocation scans bitmap words one per cycle through the
// single read port of the bitmap RAM, up to ceil(min(group_size, bitmap bits)
// / WORD_BITS) words (512 at the defaults), then reads each word of the run and
// writes it back with the run's bits set.
// After reset the bitmap RAM is zeroed one word per cycle, all MAP_BYTES * 8 /
// WORD_BITS words (512 at the defaults), while req_chan.ready stays low.
// When the receiver stalls, the result holds in the output register while the
// queue keeps taking up to two further requests.
module bitmap_contiguous_block_allocator_core import bcba_pkg::*; #(
   parameter int MAP_BYTES = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   bcba_req_if.sink               req_chan,
   bcba_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int MAP_WORDS = (MAP_BYTES * 8) / WORD_BITS;

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    clearing;

   // Configuration registers; an index past the last register is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GROUP_SIZE: cfg_in.group_size     = csr_wdata;
            CSR_GROUP_NUM:  cfg_in.group_number   = csr_wdata;
            CSR_PRESENT:    cfg_in.bitmap_present = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_size     <= GROUP_SIZE_RESET;
         cfg_ff.group_number   <= '0;
         cfg_ff.bitmap_present <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end classifies requests; the queue lets it keep taking
   // transfers while the back end scans.
   bcba_front #(.MAP_WORDS(MAP_WORDS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (!clearing),
      .bitmap_present (cfg_ff.bitmap_present),
      .req            (req_chan),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // The back end owns the bitmap, the free count and the result register.
   bcba_back #(.MAP_WORDS(MAP_WORDS), .WORD_BITS(WORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   // The back end never takes a command from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");

   // No request is taken while the bitmap is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(req_chan.valid && req_chan.ready))
      else $error("request accepted during bitmap clear");

   // A failed allocation never reports a block number.
   a_error_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |-> (rsp_chan.physical_block == '0))
      else $error("error result carries a block number");
`endif

endmodule
